// ----- design/tve_pkg.sv -----
package tve_pkg;

   // field and datapath widths
   localparam int SegWidth    = 11;
   localparam int QuoWidth    = 17;
   localparam int NumWidth    = SegWidth + QuoWidth;
   localparam int AngWidth    = 16;
   localparam int XyWidth     = 34;
   localparam int ZWidth      = 33;
   localparam int TrigWidth   = 32;
   localparam int RadWidth    = 24;
   localparam int RhoWidth    = 28;
   localparam int AtanEntries = 24;

   localparam logic [QuoWidth-1:0] FullTurn  = 17'h10000;
   localparam logic [XyWidth-1:0]  CordicGain = 34'd652032875;

   // output ranges
   localparam longint PosXyMin = -33554432;
   localparam longint PosXyMax = 33554431;
   localparam longint PosZMin  = -16777216;
   localparam longint PosZMax  = 16777215;
   localparam longint NormMin  = -16384;
   localparam longint NormMax  = 16384;

   typedef enum logic [2:0] {
      CSR_MAJOR_RADIUS  = 3'd0,
      CSR_TUBE_RADIUS   = 3'd1,
      CSR_RING_SEGMENTS = 3'd2,
      CSR_TUBE_SEGMENTS = 3'd3,
      CSR_SWEEP_ARC     = 3'd4,
      CSR_RING_START    = 3'd5,
      CSR_RING_LENGTH   = 3'd6
   } csr_index_type;

   // one long-division lane: partial remainder, then dividend bits turning into quotient bits
   typedef struct packed {
      logic [SegWidth-1:0] rem;
      logic [QuoWidth-1:0] acc;
   } div_lane_type;

   typedef struct packed {
      logic         valid;
      logic         err;
      div_lane_type u;
      div_lane_type v;
      div_lane_type tu;
      div_lane_type tv;
   } div_beat_type;

   typedef struct packed {
      logic signed [XyWidth-1:0] x;
      logic signed [XyWidth-1:0] y;
      logic signed [ZWidth-1:0]  z;
      logic [1:0]                quad;
   } cordic_rot_type;

   typedef struct packed {
      logic                valid;
      logic                err;
      logic [QuoWidth-1:0] tex_u;
      logic [QuoWidth-1:0] tex_v;
      cordic_rot_type      ru;
      cordic_rot_type      rv;
   } cordic_beat_type;

   typedef struct packed {
      logic signed [TrigWidth-1:0] c;
      logic signed [TrigWidth-1:0] s;
   } trig_type;

   // atan(2^-k) in 2^-32 turn
   function automatic logic signed [ZWidth-1:0] atan_turns(input int k);
      logic signed [ZWidth-1:0] a;
      case (k)
         0:  a = 33'sd536870912;
         1:  a = 33'sd316933406;
         2:  a = 33'sd167458907;
         3:  a = 33'sd85004756;
         4:  a = 33'sd42667331;
         5:  a = 33'sd21354465;
         6:  a = 33'sd10679838;
         7:  a = 33'sd5340245;
         8:  a = 33'sd2670163;
         9:  a = 33'sd1335087;
         10: a = 33'sd667544;
         11: a = 33'sd333772;
         12: a = 33'sd166886;
         13: a = 33'sd83443;
         14: a = 33'sd41722;
         15: a = 33'sd20861;
         16: a = 33'sd10430;
         17: a = 33'sd5215;
         18: a = 33'sd2608;
         19: a = 33'sd1304;
         20: a = 33'sd652;
         21: a = 33'sd326;
         22: a = 33'sd163;
         23: a = 33'sd81;
         default: a = '0;
      endcase
      return a;
   endfunction

   // one restoring division step
   function automatic div_lane_type div_step(input div_lane_type l,
                                             input logic [SegWidth-1:0] d);
      logic [SegWidth:0] t;
      logic              take;
      div_lane_type      r;
      t      = {l.rem, l.acc[QuoWidth-1]};
      take   = (t >= {1'b0, d});
      r.rem  = take ? SegWidth'(t - {1'b0, d}) : t[SegWidth-1:0];
      r.acc  = {l.acc[QuoWidth-2:0], take};
      return r;
   endfunction

   function automatic div_lane_type div_init(input logic [NumWidth-1:0] n);
      div_lane_type r;
      r.rem = n[NumWidth-1:QuoWidth];
      r.acc = n[QuoWidth-1:0];
      return r;
   endfunction

   // quarter-turn reduction and rotator start value
   function automatic cordic_rot_type cordic_init(input logic [AngWidth-1:0] a);
      logic [AngWidth-1:0] t;
      logic [31:0]         zw;
      cordic_rot_type      r;
      t      = a + 16'h2000;
      r.quad = t[15:14];
      zw     = {a, 16'h0} - {r.quad, 30'h0};
      r.z    = ZWidth'($signed(zw));
      r.x    = CordicGain;
      r.y    = '0;
      return r;
   endfunction

   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int s);
      logic signed [63:0] t;
      t = v + (64'sd1 <<< (s - 1));
      return t >>> s;
   endfunction

   function automatic logic signed [63:0] clamp(input logic signed [63:0] v,
                                                input longint lo, input longint hi);
      logic signed [63:0] r;
      r = v;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end
      return r;
   endfunction

endpackage

// ----- design/tve_div_cell.sv -----
module tve_div_cell
   import tve_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic [SegWidth-1:0] tube_div,
   input  logic [SegWidth-1:0] ring_div,
   input  div_beat_type        beat_in,
   output div_beat_type        beat_out
);

   div_beat_type beat_ff;
   div_beat_type beat_in_next;

   // one quotient bit for all four lanes
   always_comb begin
      beat_in_next       = beat_in;
      beat_in_next.u     = div_step(beat_in.u, tube_div);
      beat_in_next.tu    = div_step(beat_in.tu, tube_div);
      beat_in_next.v     = div_step(beat_in.v, ring_div);
      beat_in_next.tv    = div_step(beat_in.tv, ring_div);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else if (adv) begin
         beat_ff <= beat_in_next;
      end
   end

   assign beat_out = beat_ff;

endmodule

// ----- design/tve_cordic_cell.sv -----
module tve_cordic_cell
   import tve_pkg::*;
#(
   parameter int Shift = 0
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  cordic_beat_type beat_in,
   output cordic_beat_type beat_out
);

   cordic_beat_type beat_ff;
   cordic_beat_type beat_in_next;

   function automatic cordic_rot_type rot_step(input cordic_rot_type r);
      logic signed [XyWidth-1:0] x;
      logic signed [XyWidth-1:0] y;
      logic signed [XyWidth-1:0] dx;
      logic signed [XyWidth-1:0] dy;
      logic signed [ZWidth-1:0]  z;
      logic signed [ZWidth-1:0]  at;
      cordic_rot_type            o;
      x  = r.x;
      y  = r.y;
      z  = r.z;
      dx = y >>> Shift;
      dy = x >>> Shift;
      at = atan_turns(Shift);
      o.quad = r.quad;
      if (z >= 0) begin
         o.x = x - dx;
         o.y = y + dy;
         o.z = z - at;
      end else begin
         o.x = x + dx;
         o.y = y - dy;
         o.z = z + at;
      end
      return o;
   endfunction

   // one micro-rotation on both angles
   always_comb begin
      beat_in_next    = beat_in;
      beat_in_next.ru = rot_step(beat_in.ru);
      beat_in_next.rv = rot_step(beat_in.rv);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else if (adv) begin
         beat_ff <= beat_in_next;
      end
   end

   assign beat_out = beat_ff;

endmodule

// ----- design/tve_vertex_math.sv -----
module tve_vertex_math
   import tve_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic [RadWidth-1:0] major_radius,
   input  logic [RadWidth-1:0] tube_radius,
   input  cordic_beat_type     beat_in,
   output logic                rsp_valid,
   output logic signed [25:0]  rsp_pos_x,
   output logic signed [25:0]  rsp_pos_y,
   output logic signed [24:0]  rsp_pos_z,
   output logic signed [15:0]  rsp_norm_x,
   output logic signed [15:0]  rsp_norm_y,
   output logic signed [15:0]  rsp_norm_z,
   output logic [16:0]         rsp_tex_u,
   output logic [16:0]         rsp_tex_v,
   output logic                rsp_index_error
);

   function automatic trig_type quad_map(input cordic_rot_type r);
      trig_type t;
      case (r.quad)
         2'd0: begin
            t.c = TrigWidth'(r.x);
            t.s = TrigWidth'(r.y);
         end
         2'd1: begin
            t.c = TrigWidth'(-r.y);
            t.s = TrigWidth'(r.x);
         end
         2'd2: begin
            t.c = TrigWidth'(-r.x);
            t.s = TrigWidth'(-r.y);
         end
         default: begin
            t.c = TrigWidth'(r.y);
            t.s = TrigWidth'(-r.x);
         end
      endcase
      return t;
   endfunction

   // stage 1: quadrant fold and first products
   trig_type                     tu_w, tv_w;
   logic signed [RadWidth:0]     tube_s;
   logic                         m1_valid_ff, m1_err_ff;
   logic [QuoWidth-1:0]          m1_tex_u_ff, m1_tex_v_ff;
   logic signed [TrigWidth-1:0]  m1_cu_ff, m1_su_ff, m1_sv_ff;
   logic signed [56:0]           m1_tp_ff, m1_tz_ff, m1_tp_in, m1_tz_in;
   logic signed [63:0]           m1_ncx_ff, m1_ncy_ff, m1_ncx_in, m1_ncy_in;

   always_comb begin
      tu_w      = quad_map(beat_in.ru);
      tv_w      = quad_map(beat_in.rv);
      tube_s    = $signed({1'b0, tube_radius});
      m1_tp_in  = tube_s * tv_w.c;
      m1_tz_in  = tube_s * tv_w.s;
      m1_ncx_in = tv_w.c * tu_w.c;
      m1_ncy_in = tv_w.c * tu_w.s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (adv) begin
         m1_valid_ff <= beat_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_err_ff   <= beat_in.err;
         m1_tex_u_ff <= beat_in.tex_u;
         m1_tex_v_ff <= beat_in.tex_v;
         m1_cu_ff    <= tu_w.c;
         m1_su_ff    <= tu_w.s;
         m1_sv_ff    <= tv_w.s;
         m1_tp_ff    <= m1_tp_in;
         m1_tz_ff    <= m1_tz_in;
         m1_ncx_ff   <= m1_ncx_in;
         m1_ncy_ff   <= m1_ncy_in;
      end
   end

   // stage 2: rounding, ring radius, z and normals
   logic                         m2_valid_ff, m2_err_ff;
   logic [QuoWidth-1:0]          m2_tex_u_ff, m2_tex_v_ff;
   logic signed [TrigWidth-1:0]  m2_cu_ff, m2_su_ff;
   logic signed [RhoWidth-1:0]   m2_rho_ff, m2_rho_in;
   logic signed [24:0]           m2_pz_ff, m2_pz_in;
   logic signed [15:0]           m2_nx_ff, m2_ny_ff, m2_nz_ff;
   logic signed [15:0]           m2_nx_in, m2_ny_in, m2_nz_in;
   logic signed [63:0]           tp64, tz64, sv64, maj64;

   always_comb begin
      tp64      = m1_tp_ff;
      tz64      = m1_tz_ff;
      sv64      = m1_sv_ff;
      maj64     = $signed({40'h0, major_radius});
      m2_rho_in = RhoWidth'(maj64 + round_shift(tp64, 30));
      m2_pz_in  = 25'(clamp(round_shift(tz64, 30), PosZMin, PosZMax));
      m2_nx_in  = 16'(clamp(round_shift(round_shift(m1_ncx_ff, 30), 16),
                            NormMin, NormMax));
      m2_ny_in  = 16'(clamp(round_shift(round_shift(m1_ncy_ff, 30), 16),
                            NormMin, NormMax));
      m2_nz_in  = 16'(clamp(round_shift(sv64, 16), NormMin, NormMax));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else if (adv) begin
         m2_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m2_err_ff   <= m1_err_ff;
         m2_tex_u_ff <= m1_tex_u_ff;
         m2_tex_v_ff <= m1_tex_v_ff;
         m2_cu_ff    <= m1_cu_ff;
         m2_su_ff    <= m1_su_ff;
         m2_rho_ff   <= m2_rho_in;
         m2_pz_ff    <= m2_pz_in;
         m2_nx_ff    <= m2_nx_in;
         m2_ny_ff    <= m2_ny_in;
         m2_nz_ff    <= m2_nz_in;
      end
   end

   // stage 3: ring radius times tube angle
   logic                         m3_valid_ff, m3_err_ff;
   logic [QuoWidth-1:0]          m3_tex_u_ff, m3_tex_v_ff;
   logic signed [59:0]           m3_px_ff, m3_py_ff;
   logic signed [24:0]           m3_pz_ff;
   logic signed [15:0]           m3_nx_ff, m3_ny_ff, m3_nz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m3_valid_ff <= 1'b0;
      end else if (adv) begin
         m3_valid_ff <= m2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m3_err_ff   <= m2_err_ff;
         m3_tex_u_ff <= m2_tex_u_ff;
         m3_tex_v_ff <= m2_tex_v_ff;
         m3_px_ff    <= m2_rho_ff * m2_cu_ff;
         m3_py_ff    <= m2_rho_ff * m2_su_ff;
         m3_pz_ff    <= m2_pz_ff;
         m3_nx_ff    <= m2_nx_ff;
         m3_ny_ff    <= m2_ny_ff;
         m3_nz_ff    <= m2_nz_ff;
      end
   end

   // stage 4: final rounding, clamp and index error zeroing into the output register
   logic                valid_ff;
   logic signed [25:0]  px_ff, py_ff, px_in, py_in;
   logic signed [24:0]  pz_ff;
   logic signed [15:0]  nx_ff, ny_ff, nz_ff;
   logic [16:0]         tex_u_ff, tex_v_ff;
   logic                err_ff;
   logic signed [63:0]  px64, py64;

   always_comb begin
      px64  = m3_px_ff;
      py64  = m3_py_ff;
      px_in = 26'(clamp(round_shift(px64, 30), PosXyMin, PosXyMax));
      py_in = 26'(clamp(round_shift(py64, 30), PosXyMin, PosXyMax));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= m3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         err_ff   <= m3_err_ff;
         px_ff    <= m3_err_ff ? '0 : px_in;
         py_ff    <= m3_err_ff ? '0 : py_in;
         pz_ff    <= m3_err_ff ? '0 : m3_pz_ff;
         nx_ff    <= m3_err_ff ? '0 : m3_nx_ff;
         ny_ff    <= m3_err_ff ? '0 : m3_ny_ff;
         nz_ff    <= m3_err_ff ? '0 : m3_nz_ff;
         tex_u_ff <= m3_err_ff ? '0 : m3_tex_u_ff;
         tex_v_ff <= m3_err_ff ? '0 : m3_tex_v_ff;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_pos_x       = px_ff;
   assign rsp_pos_y       = py_ff;
   assign rsp_pos_z       = pz_ff;
   assign rsp_norm_x      = nx_ff;
   assign rsp_norm_y      = ny_ff;
   assign rsp_norm_z      = nz_ff;
   assign rsp_tex_u       = tex_u_ff;
   assign rsp_tex_v       = tex_v_ff;
   assign rsp_index_error = err_ff;

endmodule

// ----- design/torus_vertex_evaluator_core.sv -----
// Pipeline from accepted request to result: one input stage, 17 long-division cells,
//   one angle stage, CORDIC_STAGES rotator cells and four multiply/round stages.
// Throughput: one vertex per cycle; the whole chain holds while a result is stalled.
// Reset clears all valid bits and loads the register defaults; no memories to clear.
module torus_vertex_evaluator_core
   import tve_pkg::*;
#(
   parameter int MAX_SEGMENTS  = 1024,
   parameter int CORDIC_STAGES = 16
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [10:0]        req_tube_index,
   input  logic [10:0]        req_ring_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [25:0] rsp_pos_x,
   output logic signed [25:0] rsp_pos_y,
   output logic signed [24:0] rsp_pos_z,
   output logic signed [15:0] rsp_norm_x,
   output logic signed [15:0] rsp_norm_y,
   output logic signed [15:0] rsp_norm_z,
   output logic [16:0]        rsp_tex_u,
   output logic [16:0]        rsp_tex_v,
   output logic               rsp_index_error
);

   // configuration registers
   logic [RadWidth-1:0] major_radius_ff, tube_radius_ff;
   logic [SegWidth-1:0] ring_segments_ff, tube_segments_ff;
   logic [QuoWidth-1:0] sweep_arc_ff, ring_length_ff;
   logic [AngWidth-1:0] ring_start_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         major_radius_ff  <= 24'd65536;
         tube_radius_ff   <= 24'd26214;
         ring_segments_ff <= 11'd16;
         tube_segments_ff <= 11'd32;
         sweep_arc_ff     <= 17'd65536;
         ring_start_ff    <= 16'd0;
         ring_length_ff   <= 17'd65536;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_MAJOR_RADIUS:  major_radius_ff  <= csr_data;
            CSR_TUBE_RADIUS:   tube_radius_ff   <= csr_data;
            CSR_RING_SEGMENTS: ring_segments_ff <= csr_data[SegWidth-1:0];
            CSR_TUBE_SEGMENTS: tube_segments_ff <= csr_data[SegWidth-1:0];
            CSR_SWEEP_ARC:     sweep_arc_ff     <= csr_data[QuoWidth-1:0];
            CSR_RING_START:    ring_start_ff    <= csr_data[AngWidth-1:0];
            CSR_RING_LENGTH:   ring_length_ff   <= csr_data[QuoWidth-1:0];
            default: ;
         endcase
      end
   end

   // effective counts and saturated angles
   logic [SegWidth-1:0] tube_div, ring_div;
   logic [QuoWidth-1:0] arc_sat, len_sat;

   function automatic logic [SegWidth-1:0] eff_seg(input logic [SegWidth-1:0] r);
      logic [SegWidth-1:0] e;
      e = r;
      if (r == '0) begin
         e = SegWidth'(1);
      end else if (int'(r) > MAX_SEGMENTS) begin
         e = SegWidth'(MAX_SEGMENTS);
      end
      return e;
   endfunction

   always_comb begin
      tube_div = eff_seg(tube_segments_ff);
      ring_div = eff_seg(ring_segments_ff);
      arc_sat  = (sweep_arc_ff > FullTurn) ? FullTurn : sweep_arc_ff;
      len_sat  = (ring_length_ff > FullTurn) ? FullTurn : ring_length_ff;
   end

   // pipeline moves unless a finished result is held
   logic adv;
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // input stage: index check and dividends
   div_beat_type s0_in, s0_ff;

   always_comb begin
      s0_in.valid = req_valid;
      s0_in.err   = (req_tube_index > tube_div) || (req_ring_index > ring_div);
      s0_in.u     = div_init(NumWidth'(req_tube_index) * NumWidth'(arc_sat));
      s0_in.v     = div_init(NumWidth'(req_ring_index) * NumWidth'(len_sat));
      s0_in.tu    = div_init(NumWidth'({req_tube_index, 16'h0}));
      s0_in.tv    = div_init(NumWidth'({req_ring_index, 16'h0}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.valid <= 1'b0;
      end else if (adv) begin
         s0_ff <= s0_in;
      end
   end

   // divider chain, one quotient bit per cell
   div_beat_type div_chain [0:QuoWidth];
   assign div_chain[0] = s0_ff;

   for (genvar g = 0; g < QuoWidth; g++) begin : g_div
      tve_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .tube_div (tube_div),
         .ring_div (ring_div),
         .beat_in  (div_chain[g]),
         .beat_out (div_chain[g+1])
      );
   end

   // angle stage: wrap angles and reduce to a quarter turn
   cordic_beat_type ang_in, ang_ff;
   div_beat_type    dq;
   logic [AngWidth-1:0] u_ang, v_ang;

   always_comb begin
      dq           = div_chain[QuoWidth];
      u_ang        = dq.u.acc[AngWidth-1:0];
      v_ang        = ring_start_ff + dq.v.acc[AngWidth-1:0];
      ang_in.valid = dq.valid;
      ang_in.err   = dq.err;
      ang_in.tex_u = dq.tu.acc;
      ang_in.tex_v = dq.tv.acc;
      ang_in.ru    = cordic_init(u_ang);
      ang_in.rv    = cordic_init(v_ang);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_ff.valid <= 1'b0;
      end else if (adv) begin
         ang_ff <= ang_in;
      end
   end

   // rotator chain
   cordic_beat_type cor_chain [0:CORDIC_STAGES];
   assign cor_chain[0] = ang_ff;

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
      tve_cordic_cell #(.Shift(g)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .beat_in  (cor_chain[g]),
         .beat_out (cor_chain[g+1])
      );
   end

   // products, rounding and output register
   tve_vertex_math u_math (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .major_radius    (major_radius_ff),
      .tube_radius     (tube_radius_ff),
      .beat_in         (cor_chain[CORDIC_STAGES]),
      .rsp_valid       (rsp_valid),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_pos_z       (rsp_pos_z),
      .rsp_norm_x      (rsp_norm_x),
      .rsp_norm_y      (rsp_norm_y),
      .rsp_norm_z      (rsp_norm_z),
      .rsp_tex_u       (rsp_tex_u),
      .rsp_tex_v       (rsp_tex_v),
      .rsp_index_error (rsp_index_error)
   );

   // input only backs up behind a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a held result");

   // an out-of-range beat carries zero geometry
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_index_error) |->
         (rsp_pos_x == 0 && rsp_pos_y == 0 && rsp_pos_z == 0 &&
          rsp_tex_u == 0 && rsp_tex_v == 0))
      else $error("index error beat with nonzero fields");

   // x and z normals stay within unit range
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_norm_x >= -16'sd16384 && rsp_norm_x <= 16'sd16384 &&
                     rsp_norm_z >= -16'sd16384 && rsp_norm_z <= 16'sd16384))
      else $error("normal out of range");

endmodule
